// ===== rtl/scbo_pkg.sv =====
package scbo_pkg;

  // Fraction format of frac_delay (Q0.FRAC_BITS, one extra integer bit)
  localparam int FRAC_BITS    = 16;
  localparam int MAX_TAPS_DEF = 64;
  localparam int TAP_W        = 6;

  // register indexes on the config port
  localparam logic [2:0] REG_COS_ANGLE    = 3'd0;
  localparam logic [2:0] REG_SIN_ANGLE    = 3'd1;
  localparam logic [2:0] REG_TWICE_CUTOFF = 3'd2;
  localparam logic [2:0] REG_TAP_COUNT    = 3'd3;

  // start position (frac - centre), signed Q.FRAC_BITS
  localparam int POS_W = FRAC_BITS + 7;
  // |pi * x| in Q.(29 + FRAC_BITS); x stays well below 2^(FRAC_BITS + 7)
  localparam int DEN_W = FRAC_BITS + 37;
  localparam int D_W   = DEN_W + 1;
  localparam int REM_W = DEN_W + 1;

  // round(pi * 2^29)
  localparam logic signed [31:0] PI_Q29 = 32'sd1686629713;
  // pi * x moves by this much from one tap to the next
  localparam logic [D_W-1:0] D_STEP = {{(D_W-32){1'b0}}, PI_Q29} << FRAC_BITS;

  typedef struct packed {
    logic [16:0]        frac_delay;
    logic signed [31:0] sin_phase;
    logic signed [31:0] cos_phase;
  } request_t;

  typedef struct packed {
    logic signed [31:0] coefficient;
    logic [TAP_W-1:0]   tap_number;
    logic               last_tap;
  } result_t;

  // divide job handed from the sequencer to the divider
  typedef struct packed {
    logic             load;
    logic [31:0]      num;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
  } div_req_t;

  typedef struct packed {
    logic        ready;
    logic        done;
    logic [31:0] coef;
  } div_rsp_t;

endpackage

// ===== rtl/scbo_mul.sv =====
module scbo_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic               done,
  output logic signed [63:0] product
);

  // Radix-2 shift-add signed multiplier: one multiplier bit per cycle.
  // The sign bit of b carries weight -2^31, so the last step subtracts.
  logic               running;
  logic [4:0]         cnt;
  logic signed [31:0] mcand;
  logic signed [33:0] hi;
  logic [31:0]        lo;

  logic signed [33:0] addend;
  logic signed [33:0] sum;

  always_comb begin
    addend = '0;
    if (lo[0]) begin
      if (cnt == 5'd31) begin
        addend = -{{2{mcand[31]}}, mcand};
      end else begin
        addend = {{2{mcand[31]}}, mcand};
      end
    end
    sum = hi + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        mcand   <= a;
        hi      <= '0;
        lo      <= b;
      end else if (running) begin
        hi  <= sum >>> 1;
        lo  <= {sum[0], lo[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign product = {hi[31:0], lo};

endmodule

// ===== rtl/scbo_div.sv =====
module scbo_div (
  input  logic                clk,
  input  logic                rst,
  input  scbo_pkg::div_req_t  req,
  input  logic [30:0]         twice_cutoff,
  output scbo_pkg::div_rsp_t  rsp
);
  import scbo_pkg::*;

  // Restoring divider for |u0| * 2^(29 + FRAC_BITS) / |pi * x|.
  // The integer part is checked once against 2^32 (saturation), then
  // 32 quotient bits come out one per cycle, then round and saturate.
  typedef enum logic [2:0] {
    D_IDLE,
    D_CHECK,
    D_STEP,
    D_ROUND,
    D_SAT
  } dstate_t;

  dstate_t          state;
  logic [REM_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [31:0]      q;
  logic [32:0]      qr;
  logic [4:0]       cnt;
  logic             neg;
  logic             zero;
  logic             ovf;
  logic             done;
  logic [31:0]      coef;

  logic [REM_W-1:0] den_x;
  logic [REM_W-1:0] r2;
  logic             ge;
  logic             ge_now;

  always_comb begin
    den_x  = {1'b0, den};
    r2     = {rem[REM_W-2:0], 1'b0};
    ge     = (r2 >= den_x);
    ge_now = (rem >= den_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      ovf   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.load) begin
            rem   <= REM_W'(req.num) << (FRAC_BITS - 3);
            den   <= req.den;
            neg   <= req.neg;
            zero  <= req.zero;
            ovf   <= 1'b0;
            q     <= '0;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          if (zero) begin
            // x is exactly zero: the tap is the cutoff term
            coef  <= {1'b0, twice_cutoff};
            done  <= 1'b1;
            state <= D_IDLE;
          end else if (ge_now) begin
            ovf   <= 1'b1;
            state <= D_SAT;
          end else begin
            cnt   <= '0;
            state <= D_STEP;
          end
        end
        D_STEP: begin
          rem <= ge ? (r2 - den_x) : r2;
          q   <= {q[30:0], ge};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= D_ROUND;
          end
        end
        D_ROUND: begin
          // halves round away from zero on the magnitude
          qr    <= {1'b0, q} + {32'd0, ge};
          state <= D_SAT;
        end
        D_SAT: begin
          if (ovf || qr[32] || qr[31]) begin
            coef <= neg ? 32'h8000_0000 : 32'h7fff_ffff;
          end else begin
            coef <= neg ? (~qr[31:0] + 32'd1) : qr[31:0];
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.ready = (state == D_IDLE);
  assign rsp.done  = done;
  assign rsp.coef  = coef;

  // remainder stays below the divisor through the bit loop
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == D_STEP |-> rem < den_x)
    else $error("divider remainder not below divisor");

  // a result is only flagged as the unit goes back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == D_IDLE)
    else $error("divider done while still working");

  // a new job never lands on a job in progress
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    req.load |-> state == D_IDLE)
    else $error("divider loaded while busy");

endmodule

// ===== rtl/sinc_coeff_biquad_oscillator.sv =====
// Flow: an accepted request runs seven setup multiplies on the one bit-serial
// multiplier, then each tap takes a resonator multiply and a divide; the divide of
// one tap runs while the resonator multiply of the next one is under way.
// A new request is taken only while idle; busy stays high until the last tap
// is out. Results cannot be stalled by the receiver.
// Reset (rst, synchronous): sequencer idle, config back to its defaults.
module sinc_coeff_biquad_oscillator #(
  parameter int MAX_TAPS = scbo_pkg::MAX_TAPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  scbo_pkg::request_t request,
  output logic               strobe,
  output scbo_pkg::result_t  result,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import scbo_pkg::*;

  localparam int IDX_W = $clog2(MAX_TAPS + 1);

  localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CC,
    S_SC,
    S_N1,
    S_N2,
    S_O1,
    S_O2,
    S_PD,
    S_U0,
    S_HAND,
    S_DRAIN
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // configuration registers
  logic signed [31:0] cos_angle;
  logic signed [31:0] sin_angle;
  logic [30:0]        twice_cutoff;
  logic [6:0]         tap_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle    <= 32'sd1073741824;
      sin_angle    <= '0;
      twice_cutoff <= 31'd1073741824;
      tap_count    <= 7'd15;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COS_ANGLE:    cos_angle    <= cfg_data;
        REG_SIN_ANGLE:    sin_angle    <= cfg_data;
        REG_TWICE_CUTOFF: twice_cutoff <= cfg_data[30:0];
        REG_TAP_COUNT:    tap_count    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t                    state;
  logic signed [31:0]        sn_p;
  logic signed [31:0]        cs_p;
  logic signed [POS_W-1:0]   pos;
  logic signed [31:0]        cos2;
  logic signed [31:0]        sin2;
  logic signed [34:0]        acc;
  logic signed [31:0]        osc_newer;
  logic signed [31:0]        osc_older;
  logic signed [31:0]        u0_hold;
  logic signed [D_W-1:0]     dpos;
  logic [IDX_W-1:0]          n_taps;
  logic [IDX_W-1:0]          idx;
  logic                      mul_start;
  div_req_t                  div_req;
  logic [TAP_W-1:0]          div_tap;
  logic                      div_last;

  // multiplier and divider
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic               mul_done;
  logic signed [63:0] prod;
  div_rsp_t           div_rsp;

  scbo_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (prod)
  );

  scbo_div u_div (
    .clk          (clk),
    .rst          (rst),
    .req          (div_req),
    .twice_cutoff (twice_cutoff),
    .rsp          (div_rsp)
  );

  // operand select per step
  always_comb begin
    case (state)
      S_CC:    begin mul_a = cos_angle; mul_b = cos_angle; end
      S_SC:    begin mul_a = sin_angle; mul_b = cos_angle; end
      S_N1:    begin mul_a = sn_p;      mul_b = cos_angle; end
      S_N2:    begin mul_a = cs_p;      mul_b = sin_angle; end
      S_O1:    begin mul_a = sn_p;      mul_b = cos2;      end
      S_O2:    begin mul_a = cs_p;      mul_b = sin2;      end
      S_PD:    begin mul_a = PI_Q29;    mul_b = {{(32-POS_W){pos[POS_W-1]}}, pos}; end
      S_U0:    begin mul_a = cos_angle; mul_b = osc_newer; end
      default: begin mul_a = cos_angle; mul_b = cos_angle; end
    endcase
  end

  // product rounding: floor((p + 2^(n-1)) / 2^n)
  logic signed [33:0] rr30;
  logic signed [34:0] rr29;
  logic signed [35:0] rr30_x;
  logic signed [35:0] rr29_x;
  logic signed [35:0] acc_x;
  logic signed [35:0] older_x;
  logic signed [35:0] cos2_x;

  assign rr30    = prod[63:30] + {33'd0, prod[29]};
  assign rr29    = prod[63:29] + {34'd0, prod[28]};
  assign rr30_x  = {{2{rr30[33]}}, rr30};
  assign rr29_x  = {rr29[34], rr29};
  assign acc_x   = {acc[34], acc};
  assign older_x = {{4{osc_older[31]}}, osc_older};
  assign cos2_x  = (rr30_x <<< 1) - Q30_ONE;

  // request decode: effective tap count and start position
  logic [6:0]              n_eff;
  logic [6:0]              centre;
  logic signed [POS_W-1:0] pos_start;

  always_comb begin
    n_eff     = (tap_count > 7'(MAX_TAPS)) ? 7'(MAX_TAPS) : tap_count;
    centre    = (n_eff + 7'd1) >> 1;
    pos_start = $signed({{(POS_W-FRAC_BITS-1){1'b0}}, request.frac_delay[FRAC_BITS:0]})
              - $signed({centre, {FRAC_BITS{1'b0}}});
  end

  // magnitudes and sign for the divide job
  logic [31:0]    u_abs;
  logic [D_W-1:0] d_abs;
  logic           tap_last;

  always_comb begin
    u_abs    = u0_hold[31] ? (~u0_hold + 32'd1) : u0_hold;
    d_abs    = dpos[D_W-1] ? (~dpos + {{(D_W-1){1'b0}}, 1'b1}) : dpos;
    tap_last = (IDX_W'(idx + 1'b1) == n_taps);
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mul_start    <= 1'b0;
      div_req.load <= 1'b0;
      strobe       <= 1'b0;
      idx          <= '0;
      n_taps       <= '0;
    end else begin
      mul_start    <= 1'b0;
      div_req.load <= 1'b0;
      strobe       <= 1'b0;

      // finished taps go straight out
      if (div_rsp.done) begin
        strobe             <= 1'b1;
        result.coefficient <= div_rsp.coef;
        result.tap_number  <= div_tap;
        result.last_tap    <= div_last;
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            sn_p   <= request.sin_phase;
            cs_p   <= request.cos_phase;
            pos    <= pos_start;
            n_taps <= IDX_W'(n_eff);
            idx    <= '0;
            if (n_eff != 7'd0) begin
              mul_start <= 1'b1;
              state     <= S_CC;
            end
          end
        end
        S_CC: begin
          if (mul_done) begin
            cos2      <= sat32(cos2_x);
            mul_start <= 1'b1;
            state     <= S_SC;
          end
        end
        S_SC: begin
          if (mul_done) begin
            sin2      <= sat32(rr29_x);
            mul_start <= 1'b1;
            state     <= S_N1;
          end
        end
        S_N1: begin
          if (mul_done) begin
            acc       <= rr30_x[34:0];
            mul_start <= 1'b1;
            state     <= S_N2;
          end
        end
        S_N2: begin
          if (mul_done) begin
            osc_newer <= sat32(acc_x - rr30_x);
            mul_start <= 1'b1;
            state     <= S_O1;
          end
        end
        S_O1: begin
          if (mul_done) begin
            acc       <= rr30_x[34:0];
            mul_start <= 1'b1;
            state     <= S_O2;
          end
        end
        S_O2: begin
          if (mul_done) begin
            osc_older <= sat32(acc_x - rr30_x);
            mul_start <= 1'b1;
            state     <= S_PD;
          end
        end
        S_PD: begin
          if (mul_done) begin
            dpos      <= prod[D_W-1:0];
            mul_start <= 1'b1;
            state     <= S_U0;
          end
        end
        S_U0: begin
          // resonator step u0 = 2cos(w) * u1 - u2
          if (mul_done) begin
            u0_hold <= sat32(rr29_x - older_x);
            state   <= S_HAND;
          end
        end
        S_HAND: begin
          if (div_rsp.ready) begin
            div_req.load <= 1'b1;
            div_req.num  <= u_abs;
            div_req.den  <= d_abs[DEN_W-1:0];
            div_req.neg  <= u0_hold[31] ^ dpos[D_W-1];
            div_req.zero <= (dpos == '0);
            div_tap      <= TAP_W'(idx);
            div_last     <= tap_last;
            osc_older    <= osc_newer;
            osc_newer    <= u0_hold;
            dpos         <= dpos + $signed(D_STEP);
            idx          <= idx + 1'b1;
            if (tap_last) begin
              state <= S_DRAIN;
            end else begin
              mul_start <= 1'b1;
              state     <= S_U0;
            end
          end
        end
        S_DRAIN: begin
          if (div_rsp.done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the final tap of a run closes the run
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_tap |-> state == S_IDLE)
    else $error("run still active after its last tap");

  // any other tap leaves the run going
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_tap |-> busy)
    else $error("run ended before its last tap");

  // tap index never passes the run length
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= n_taps)
    else $error("tap index beyond tap count");

endmodule

// ===== bench/sinc_coeff_biquad_oscillator_tb.sv =====
module sinc_coeff_biquad_oscillator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scbo_pkg::*;

  localparam logic [2:0] REG_FIRST_UNUSED = 3'd4;
  localparam logic [2:0] REG_LAST_UNUSED  = 3'd7;

  localparam int  RANDOM_ITEMS   = 200;
  localparam int  CALM_ITEMS     = 40;
  localparam int  SETTLE_CYCLES  = 320;
  localparam int  TAIL_CYCLES    = 400;
  localparam int  STALL_LIMIT    = 6000;
  localparam int  MAX_REPORTS    = 10;
  localparam real PI_REAL        = 3.141592653589793;
  localparam longint Q30_ONE     = 64'sd1073741824;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     start     = 1'b0;
  logic     busy;
  request_t request   = '0;
  logic     strobe;
  result_t  result;
  logic     cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  sinc_coeff_biquad_oscillator DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .strobe    (strobe),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the register file, reset values
  longint      cfg_cos    = Q30_ONE;
  longint      cfg_sin    = 0;
  longint      cfg_twice  = Q30_ONE;
  int unsigned cfg_taps   = 15;
  real         cur_omega  = 0.0;

  // resonator state of the predictor
  longint res_u1 = 0;
  longint res_u2 = 0;

  result_t pending_taps[$];

  int error_count    = 0;
  int requests_sent  = 0;
  int formed_sent    = 0;
  int noise_sent     = 0;
  int taps_checked   = 0;
  int settings_count = 0;
  int stall_cycles   = 0;

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor((v + 2^(n-1)) / 2^n)
  function automatic longint round_shift(longint v, int n);
    longint y;
    y = v + (longint'(1) << (n - 1));
    return y >>> n;
  endfunction

  // u0 / (pi * x), magnitude rounded half away from zero, then saturated
  function automatic logic signed [31:0] sinc_tap(longint u0, longint xq);
    bit         neg;
    bit [127:0] num;
    bit [127:0] den;
    bit [127:0] q;
    neg = (u0 < 0) != (xq < 0);
    num = 128'(u0 < 0 ? -u0 : u0);
    den = 128'(longint'(PI_Q29)) * 128'(xq < 0 ? -xq : xq);
    q   = ((num << (29 + FRAC_BITS + 1)) + den) / (den << 1);
    if (neg) begin
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      return -q[31:0];
    end
    if (q > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic void predict_taps(request_t req);
    int unsigned n;
    int unsigned centre;
    longint      pos;
    longint      cos2;
    longint      sin2;
    longint      sp;
    longint      cp;
    longint      u0;
    longint      xq;
    longint      coef;
    result_t     tap;
    n = (cfg_taps > MAX_TAPS_DEF) ? MAX_TAPS_DEF : cfg_taps;
    if (n == 0) return;
    centre = (n + 1) / 2;
    pos  = longint'(req.frac_delay) - (longint'(centre) << FRAC_BITS);
    sp   = longint'($signed(req.sin_phase));
    cp   = longint'($signed(req.cos_phase));
    cos2 = clamp32(2 * round_shift(cfg_cos * cfg_cos, 30) - Q30_ONE);
    sin2 = clamp32(round_shift(cfg_sin * cfg_cos, 29));
    // seed with sin(phi - w) and sin(phi - 2w)
    res_u1 = clamp32(round_shift(sp * cfg_cos, 30) - round_shift(cp * cfg_sin, 30));
    res_u2 = clamp32(round_shift(sp * cos2, 30) - round_shift(cp * sin2, 30));
    for (int unsigned i = 0; i < n; i++) begin
      u0 = clamp32(round_shift(cfg_cos * res_u1, 29) - res_u2);
      res_u2 = res_u1;
      res_u1 = u0;
      xq = (longint'(i) << FRAC_BITS) + pos;
      coef = (xq == 0) ? cfg_twice : longint'(sinc_tap(u0, xq));
      tap.coefficient = coef[31:0];
      tap.tap_number  = i[TAP_W-1:0];
      tap.last_tap    = (i + 1 == n);
      pending_taps.insert(pending_taps.size(), tap);
    end
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_COS_ANGLE:    cfg_cos   = longint'($signed(data));
      REG_SIN_ANGLE:    cfg_sin   = longint'($signed(data));
      REG_TWICE_CUTOFF: cfg_twice = longint'(data[30:0]);
      REG_TAP_COUNT:    cfg_taps  = data[6:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void log_failure(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // results sampled mid-cycle, where strobe and result are stable
  always @(negedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (pending_taps.size() == 0) begin
        log_failure($sformatf("unexpected tap: coef %0d tap %0d last %0b",
                              result.coefficient, result.tap_number, result.last_tap));
      end else begin
        want = pending_taps.pop_front();
        taps_checked++;
        if (result.coefficient !== want.coefficient ||
            result.tap_number !== want.tap_number ||
            result.last_tap !== want.last_tap) begin
          log_failure($sformatf(
            "tap mismatch: expected coef %0d tap %0d last %0b, got coef %0d tap %0d last %0b",
            want.coefficient, want.tap_number, want.last_tap,
            result.coefficient, result.tap_number, result.last_tap));
        end
      end
    end
  end

  // cycles with no handshake of any kind
  always @(negedge clk) begin
    if (rst || strobe || cfg_write || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  function automatic int q30(real v);
    return int'(v * 1073741824.0);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 3) return $urandom_range(1, 19);
    return 0;
  endfunction

  // start stays high after acceptance; the next caller lowers it or reuses it
  task automatic send_request(input request_t req, input int gap);
    bit taken;
    if (gap > 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(negedge clk); while (busy);
        @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    predict_taps(req);
    requests_sent++;
  endtask

  // wait until every tap is out and the block has gone idle
  task automatic settle_block();
    start <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] ca, input logic [31:0] sa,
                           input logic [31:0] tc, input logic [31:0] taps);
    settle_block();
    write_reg(REG_COS_ANGLE, ca);
    write_reg(REG_SIN_ANGLE, sa);
    write_reg(REG_TWICE_CUTOFF, tc);
    write_reg(REG_TAP_COUNT, taps);
    settings_count++;
  endtask

  task automatic set_cutoff(input real fc, input int taps);
    cur_omega = 2.0 * PI_REAL * fc;
    configure(q30($cos(cur_omega)), q30($sin(cur_omega)), q30(2.0 * fc), taps);
  endtask

  // request whose start phase matches the current angle and tap count
  function automatic request_t formed_request();
    request_t    req;
    int unsigned n;
    int unsigned frac;
    real         phi;
    n = (cfg_taps > MAX_TAPS_DEF) ? MAX_TAPS_DEF : cfg_taps;
    if ($urandom_range(0, 4) == 0) frac = $urandom_range(0, 1) ? 65536 : 0;
    else frac = $urandom_range(0, 65536);
    phi = (real'(frac) / 65536.0 - real'((n + 1) / 2)) * cur_omega;
    req.frac_delay = frac[16:0];
    req.sin_phase  = q30($sin(phi));
    req.cos_phase  = q30($cos(phi));
    return req;
  endfunction

  function automatic request_t noise_request();
    request_t req;
    req.frac_delay = 17'($urandom());
    req.sin_phase  = $urandom();
    req.cos_phase  = $urandom();
    return req;
  endfunction

  function automatic request_t make_request(int frac, int sp, int cp);
    request_t req;
    req.frac_delay = frac[16:0];
    req.sin_phase  = sp;
    req.cos_phase  = cp;
    return req;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic reset_block();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // reset values: zero angle; with zero sin phase every tap but the centre one is zero
  task automatic test_default_config();
    send_request(make_request(0, 0, 32'sd1073741824), 0);
    send_request(make_request(65536, 0, 32'sd1073741824), 0);
    send_request(make_request(32768, q30(0.5), q30(0.8660254)), 0);
  endtask

  task automatic test_field_extremes();
    set_cutoff(0.2, 9);
    send_request(make_request(32'h1FFFF, 32'sh7FFFFFFF, 32'sh80000000), 0);
    send_request(make_request(0, 32'sh80000000, 32'sh7FFFFFFF), 0);
    send_request(make_request(65536, 32'sd1073741824, -32'sd1073741824), 0);
    send_request(make_request(1, -32'sd1073741824, 32'sd1073741824), 0);
  endtask

  // one tap, two taps, full length, none, and counts above the maximum
  task automatic test_tap_count_limits();
    set_cutoff(0.1, 1);
    send_request(formed_request(), 0);
    set_cutoff(0.3, 2);
    send_request(formed_request(), 0);
    set_cutoff(0.05, 64);
    send_request(formed_request(), 0);
    set_cutoff(0.1, 0);
    send_request(formed_request(), 0);
    set_cutoff(0.45, 127);
    send_request(formed_request(), 0);
    set_cutoff(0.25, 65);
    send_request(formed_request(), 0);
  endtask

  // angles at and past the ends of the range; past the ends, cos2 and sin2 saturate
  task automatic test_angle_extremes();
    cur_omega = 0.7;
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5);
    send_request(formed_request(), 0);
    send_request(make_request(32768, 32'sh7FFFFFFF, 32'sh7FFFFFFF), 0);
    cur_omega = PI_REAL;
    configure(-32'sd1073741824, 0, 0, 6);
    send_request(make_request(0, 0, -32'sd1073741824), 0);
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'sd1073741824, 4);
    send_request(noise_request(), 0);
  endtask

  // writes beyond the register list must leave the settings alone
  task automatic test_ignored_index();
    set_cutoff(0.15, 7);
    for (int idx = REG_FIRST_UNUSED; idx <= REG_LAST_UNUSED; idx++)
      write_reg(idx[2:0], $urandom());
    send_request(formed_request(), 0);
  endtask

  task automatic random_config();
    int unsigned taps;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) taps = $urandom_range(1, 16);
    else if (pick < 90) taps = $urandom_range(17, 64);
    else if (pick < 95) taps = 0;
    else taps = $urandom_range(65, 127);
    if ($urandom_range(0, 99) < 85) begin
      set_cutoff(real'($urandom_range(1, 49999)) / 100000.0, taps);
    end else begin
      cur_omega = 2.0 * PI_REAL * real'($urandom_range(1, 49999)) / 100000.0;
      configure($urandom(), $urandom(), $urandom(), taps);
    end
    if ($urandom_range(0, 99) < 15)
      write_reg(3'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)), $urandom());
  endtask

  // mostly matched phases with random content, some raw noise
  task automatic test_random_runs();
    int  random_sent;
    int  run_len;
    bit  calm;
    request_t req;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      random_config();
      run_len = $urandom_range(4, 14);
      for (int k = 0; k < run_len && random_sent < RANDOM_ITEMS; k++) begin
        calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
        if ($urandom_range(0, 9) < 8) begin
          req = formed_request();
          formed_sent++;
        end else begin
          req = noise_request();
          noise_sent++;
        end
        send_request(req, calm ? 0 : pick_gap());
        if (cfg_taps != 0) random_sent++;
      end
    end
  endtask

  task automatic finish_run();
    start <= 1'b0;
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_taps.size() != 0)
      log_failure($sformatf("%0d taps never arrived", pending_taps.size()));
    $display("Summary: %0d requests (%0d matched-phase, %0d noise in random part)",
             requests_sent, formed_sent, noise_sent);
    $display("Summary: %0d taps checked over %0d register settings, %0d errors",
             taps_checked, settings_count, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  endtask

  initial begin
    reset_block();
    test_default_config();
    test_field_extremes();
    test_tap_count_limits();
    test_angle_extremes();
    test_ignored_index();
    test_random_runs();
    finish_run();
  end

endmodule
